// ----- rtl/mqlb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqlb_pkg
// Shared types and constants of the multi-queue linked buffer.
// ----------------------------------------------------------------------------
package mqlb_pkg;

  // Default sizes
  localparam int NumQueuesDef   = 8;
  localparam int PoolEntriesDef = 256;

  // Fixed field widths
  localparam int ValueW = 32;
  localparam int CfgW   = 4;
  localparam int QIdxW  = 3;

  localparam logic [CfgW-1:0] ActiveQueuesRst = 4'd8;

  // Operation codes
  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_POOL_FULL = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DEQ
  } fsm_e;

  // One result transaction
  typedef struct packed {
    status_e             status;
    logic [ValueW-1:0]   value;
    logic                now_empty;
  } result_t;

endpackage

// ----- rtl/mqlb_pool.sv -----
// ----------------------------------------------------------------------------
// mqlb_pool
// Entry pool: data and link memories with registered reads. Entries that
// were never allocated read their link as the next entry in order.
// ----------------------------------------------------------------------------
module mqlb_pool #(
  parameter int POOL_ENTRIES = mqlb_pkg::PoolEntriesDef,
  localparam int PW = $clog2(POOL_ENTRIES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // read port, both memories at one address
  input  logic                        rd_en_i,
  input  logic [PW-1:0]               rd_addr_i,
  output logic [PW-1:0]               link_o,
  output logic [mqlb_pkg::ValueW-1:0] data_o,
  // link write port
  input  logic                        link_we_i,
  input  logic [PW-1:0]               link_waddr_i,
  input  logic [PW-1:0]               link_wdata_i,
  // data write port, one write per allocation
  input  logic                        data_we_i,
  input  logic [PW-1:0]               data_waddr_i,
  input  logic [mqlb_pkg::ValueW-1:0] data_wdata_i
);
  import mqlb_pkg::*;

  localparam int CW = $clog2(POOL_ENTRIES + 1);

  logic [ValueW-1:0] data_mem [POOL_ENTRIES];
  logic [PW-1:0]     link_mem [POOL_ENTRIES];

  logic [ValueW-1:0] data_rd_q;
  logic [PW-1:0]     link_rd_q;
  logic [PW-1:0]     rd_addr_q;
  logic              rd_fresh_q;
  logic [CW-1:0]     fresh_q, fresh_d;
  logic [PW-1:0]     next_entry;

  // Memories: synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (data_we_i) begin
      data_mem[data_waddr_i] <= data_wdata_i;
    end
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (rd_en_i) begin
      data_rd_q <= data_mem[rd_addr_i];
      link_rd_q <= link_mem[rd_addr_i];
    end
  end

  // Entries at or above the fill mark were never allocated
  always_comb begin
    fresh_d = fresh_q;
    if (data_we_i && (CW'(data_waddr_i) == fresh_q)) begin
      fresh_d = fresh_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q    <= '0;
      rd_fresh_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      fresh_q <= fresh_d;
      if (rd_en_i) begin
        rd_fresh_q <= (CW'(rd_addr_i) >= fresh_q);
        rd_addr_q  <= rd_addr_i;
      end
    end
  end

  // Reset-time link: next entry, the last one wraps to zero
  assign next_entry = (rd_addr_q == PW'(POOL_ENTRIES - 1)) ? '0 : rd_addr_q + PW'(1);

  assign link_o = rd_fresh_q ? next_entry : link_rd_q;
  assign data_o = data_rd_q;

endmodule

// ----- rtl/multi_queue_linked_buffer_top.sv -----
// ----------------------------------------------------------------------------
// multi_queue_linked_buffer_top
// Several FIFO queues sharing one linked entry pool with a free list.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | kind_i, queue_index_i, value_i
//  out     | output    | out_valid_o / out_stall_i| status_o, result_value_o,
//          |           |                        | now_empty_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (active queues)
//
//  Enqueues and rejected operations end in the execute state; successful
//  dequeues add FSM_DEQ: queue pointer read, then the pool read of the head entry.
//  One transaction is in work at a time; the next is accepted once the
//  previous one has written its result into the output register.
//  A stalled output register holds the finishing step until it drains.
//  Reset is asynchronous; no clearing pass, the pool uses a fill mark.
// ----------------------------------------------------------------------------
module multi_queue_linked_buffer_top #(
  parameter int NUM_QUEUES   = mqlb_pkg::NumQueuesDef,
  parameter int POOL_ENTRIES = mqlb_pkg::PoolEntriesDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [mqlb_pkg::CfgW-1:0]          cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [mqlb_pkg::QIdxW-1:0]         queue_index_i,
  input  logic signed [mqlb_pkg::ValueW-1:0] value_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [mqlb_pkg::ValueW-1:0] result_value_o,
  output logic                               now_empty_o
);
  import mqlb_pkg::*;

  localparam int PW  = $clog2(POOL_ENTRIES);
  localparam int CW  = $clog2(POOL_ENTRIES + 1);
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QIW = (QW > QIdxW) ? QW : QIdxW;

  // Control and operation registers
  fsm_e                  state_q, state_d;
  logic [CfgW-1:0]       active_q;
  kind_e                 kind_q;
  logic [QIdxW-1:0]      qidx_q;
  logic [ValueW-1:0]     val_q;
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;
  logic [PW-1:0]         free_head_q, free_head_d;
  logic [CW-1:0]         free_cnt_q, free_cnt_d;
  result_t               out_q, res;
  logic                  out_valid_q;
  logic                  res_load;

  // Queue pointer memory: {head, tail}
  logic [2*PW-1:0]       qmem [NUM_QUEUES];
  logic [2*PW-1:0]       qrd_q;
  logic                  qmem_we;
  logic [2*PW-1:0]       qmem_wdata;

  // Pool interface
  logic                  pool_rd_en;
  logic [PW-1:0]         pool_rd_addr;
  logic [PW-1:0]         pool_link;
  logic [ValueW-1:0]     pool_data;
  logic                  link_we;
  logic [PW-1:0]         link_waddr, link_wdata;
  logic                  data_we;

  logic                  accept;
  logic [QIW-1:0]        qin_ext, qop_ext;
  logic [QW-1:0]         qin_addr, qop_addr;
  logic                  idx_ok, cur_ne, out_free;
  logic [PW-1:0]         head_rd, tail_rd;

  assign in_stall_o = (state_q != FSM_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign qin_ext  = QIW'(queue_index_i);
  assign qin_addr = qin_ext[QW-1:0];
  assign qop_ext  = QIW'(qidx_q);
  assign qop_addr = qop_ext[QW-1:0];

  assign idx_ok   = (CfgW'(qidx_q) < active_q) && (32'(qidx_q) < NUM_QUEUES);
  assign cur_ne   = nonempty_q[qop_addr];
  assign out_free = !out_valid_q || !out_stall_i;
  assign head_rd  = qrd_q[2*PW-1:PW];
  assign tail_rd  = qrd_q[PW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (idx_ok && (kind_q == KIND_DEQ) && cur_ne) begin
          state_d = FSM_DEQ;
        end else if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_DEQ: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Datapath control and state updates
  always_comb begin
    pool_rd_en   = 1'b0;
    pool_rd_addr = free_head_q;
    link_we      = 1'b0;
    link_waddr   = tail_rd;
    link_wdata   = free_head_q;
    data_we      = 1'b0;
    qmem_we      = 1'b0;
    qmem_wdata   = {free_head_q, free_head_q};
    nonempty_d   = nonempty_q;
    free_head_d  = free_head_q;
    free_cnt_d   = free_cnt_q;
    res_load     = 1'b0;
    res          = '{status: STAT_OK, value: '0, now_empty: 1'b0};

    unique case (state_q)
      FSM_IDLE: begin
        // link of the free head, for an enqueue
        pool_rd_en = accept;
      end
      FSM_EXEC: begin
        if (!idx_ok) begin
          res      = '{status: STAT_BAD_INDEX, value: '0, now_empty: 1'b1};
          res_load = out_free;
        end else if (kind_q == KIND_ENQ) begin
          if (free_cnt_q == '0) begin
            res      = '{status: STAT_POOL_FULL, value: '0, now_empty: !cur_ne};
            res_load = out_free;
          end else if (out_free) begin
            res_load    = 1'b1;
            data_we     = 1'b1;
            free_head_d = pool_link;
            free_cnt_d  = free_cnt_q - CW'(1);
            qmem_we     = 1'b1;
            if (cur_ne) begin
              link_we    = 1'b1;
              qmem_wdata = {head_rd, free_head_q};
            end else begin
              nonempty_d[qop_addr] = 1'b1;
            end
          end
        end else begin
          if (!cur_ne) begin
            res      = '{status: STAT_EMPTY, value: '0, now_empty: 1'b1};
            res_load = out_free;
          end else begin
            pool_rd_en   = 1'b1;
            pool_rd_addr = head_rd;
          end
        end
      end
      FSM_DEQ: begin
        res = '{status: STAT_OK, value: pool_data, now_empty: (head_rd == tail_rd)};
        if (out_free) begin
          res_load    = 1'b1;
          // freed entry goes to the front of the free list
          link_we     = 1'b1;
          link_waddr  = head_rd;
          free_head_d = head_rd;
          if (free_cnt_q < CW'(POOL_ENTRIES)) begin
            free_cnt_d = free_cnt_q + CW'(1);
          end
          if (head_rd == tail_rd) begin
            nonempty_d[qop_addr] = 1'b0;
          end else begin
            qmem_we    = 1'b1;
            qmem_wdata = {pool_link, tail_rd};
          end
        end
      end
      default: ;
    endcase
  end

  // Queue pointer memory
  always_ff @(posedge clk_i) begin
    if (qmem_we) begin
      qmem[qop_addr] <= qmem_wdata;
    end
    if (accept) begin
      qrd_q <= qmem[qin_addr];
    end
  end

  // Operation payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(kind_i);
      qidx_q <= queue_index_i;
      val_q  <= value_i;
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      active_q    <= ActiveQueuesRst;
      nonempty_q  <= '0;
      free_head_q <= '0;
      free_cnt_q  <= CW'(POOL_ENTRIES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nonempty_q  <= nonempty_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  mqlb_pool #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_pool (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (pool_rd_en),
    .rd_addr_i    (pool_rd_addr),
    .link_o       (pool_link),
    .data_o       (pool_data),
    .link_we_i    (link_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .data_we_i    (data_we),
    .data_waddr_i (free_head_q),
    .data_wdata_i (val_q)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_value_o = out_q.value;
  assign now_empty_o    = out_q.now_empty;

`ifndef SYNTHESIS
  // free count never exceeds the pool size
  a_free_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CW'(POOL_ENTRIES))
    else $error("free count above pool size");

  // an accepted transaction always proceeds to execution
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == FSM_EXEC))
    else $error("accepted transaction did not enter execution");

  // a dequeue in progress implies at least one entry is allocated
  a_deq_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_DEQ) |-> (free_cnt_q < CW'(POOL_ENTRIES)))
    else $error("dequeue with the whole pool free");
`endif

endmodule

// ----- bench/tb_multi_queue_linked_buffer_top.sv -----
// ----------------------------------------------------------------------------
// tb_multi_queue_linked_buffer_top
// Self-checking bench for the multi-queue linked buffer. A short directed
// table covers the empty, extreme-value, bad-index and register corners.
// It is followed by random phases under different active-queue settings,
// among them one that fills the shared pool past full and one that drains it.
// Every result is checked against the typed expectation of a directed row, if it
// has one, else against an in-bench model of the queues and the free list.
// ----------------------------------------------------------------------------
module tb_multi_queue_linked_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mqlb_pkg::*;

  localparam int NumQ       = NumQueuesDef;
  localparam int PoolSize   = PoolEntriesDef;
  localparam int RandItems  = 1900;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 20;
  localparam int CycleLimit = 400000;

  // DUT connections
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CfgW-1:0]          cfg_wdata_i   = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i        = 1'b0;
  logic [QIdxW-1:0]         queue_index_i = '0;
  logic signed [ValueW-1:0] value_i       = '0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic [1:0]               status_o;
  logic signed [ValueW-1:0] result_value_o;
  logic                     now_empty_o;

  multi_queue_linked_buffer_top #(
    .NUM_QUEUES  (NumQ),
    .POOL_ENTRIES(PoolSize)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .queue_index_i (queue_index_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .result_value_o(result_value_o),
    .now_empty_o   (now_empty_o)
  );

  // Directed table rows
  typedef enum {ROW_ENQ, ROW_DEQ, ROW_CFG} row_e;

  typedef struct {
    row_e        op;
    logic [2:0]  q;
    logic [31:0] word;   // enqueue data, or register value on ROW_CFG
    bit          typed;  // expected result written in the table
    result_t     r;
  } stim_row_t;

  // Per-transaction hint: a typed expectation overrides the model output
  typedef struct packed {
    bit      use_typed;
    result_t r;
  } exp_hint_t;

  // Model state
  logic [31:0]     pool_data [PoolSize];
  logic [7:0]      pool_next [PoolSize];
  logic [7:0]      q_head    [NumQ];
  logic [7:0]      q_tail    [NumQ];
  bit              q_busy    [NumQ];
  logic [7:0]      free_head;
  logic [8:0]      free_cnt;
  logic [CfgW-1:0] active_cfg;

  result_t   pending_results[$];
  exp_hint_t typed_hints[$];
  stim_row_t plan[$];

  int  err_cnt      = 0;
  int  n_checked    = 0;
  int  n_settings   = 0;
  int  stat_seen[4] = '{0, 0, 0, 0};
  int  cycle_cnt    = 0;
  bit  hold_req     = 1'b0;
  bit  no_idle      = 1'b0;

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[multi_queue_linked_buffer_top] ERROR");
      $finish;
    end
  end

  task automatic reset_model();
    for (int i = 0; i < PoolSize; i++) begin
      pool_data[i] = '0;
      pool_next[i] = (i + 1 < PoolSize) ? 8'(i + 1) : 8'd0;
    end
    for (int i = 0; i < NumQ; i++) begin
      q_head[i] = '0;
      q_tail[i] = '0;
      q_busy[i] = 1'b0;
    end
    free_head  = '0;
    free_cnt   = 9'(PoolSize);
    active_cfg = ActiveQueuesRst;
  endtask

  // Predicts one operation and updates the queue/free-list state
  function automatic result_t apply_queue_op(kind_e k, logic [2:0] q, logic [31:0] v);
    result_t    r;
    logic [7:0] e;
    r.status    = STAT_OK;
    r.value     = '0;
    r.now_empty = 1'b0;
    // index at or above the active count (NUM_QUEUES is 8, so 3 bits always fit)
    if ({1'b0, q} >= active_cfg) begin
      r.status    = STAT_BAD_INDEX;
      r.now_empty = 1'b1;
      return r;
    end
    if (k == KIND_ENQ) begin
      if (free_cnt == 0) begin
        r.status    = STAT_POOL_FULL;
        r.now_empty = !q_busy[q];
        return r;
      end
      e            = free_head;
      free_head    = pool_next[e];
      free_cnt     = free_cnt - 1'b1;
      pool_data[e] = v;
      if (q_busy[q]) begin
        pool_next[q_tail[q]] = e;
        q_tail[q]            = e;
      end else begin
        q_head[q] = e;
        q_tail[q] = e;
        q_busy[q] = 1'b1;
      end
      return r;
    end
    if (!q_busy[q]) begin
      r.status    = STAT_EMPTY;
      r.now_empty = 1'b1;
      return r;
    end
    e       = q_head[q];
    r.value = pool_data[e];
    if (e == q_tail[q]) q_busy[q] = 1'b0;
    else q_head[q] = pool_next[e];
    // freed entry goes back on top of the free list
    pool_next[e] = free_head;
    free_head    = e;
    if (free_cnt < PoolSize) free_cnt = free_cnt + 1'b1;
    r.now_empty = !q_busy[q];
    return r;
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Monitor: register writes, accepted inputs and accepted results
  always @(posedge clk_i) begin
    exp_hint_t hint;
    result_t   pred;
    result_t   want;
    if (rst_ni) begin
      if (cfg_we_i) active_cfg = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        hint = '0;
        if (typed_hints.size() != 0) hint = typed_hints.pop_front();
        pred = apply_queue_op(kind_e'(kind_i), queue_index_i, value_i);
        pending_results.push_back(hint.use_typed ? hint.r : pred);
      end
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        stat_seen[status_o]++;
        if (pending_results.size() == 0) begin
          note_error($sformatf("result with nothing expected: status %0d value %h empty %b",
                               status_o, result_value_o, now_empty_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status || result_value_o !== want.value ||
              now_empty_o !== want.now_empty)
            note_error($sformatf("exp status %0d value %h empty %b, got %0d %h %b",
                                 want.status, want.value, want.now_empty,
                                 status_o, result_value_o, now_empty_o));
        end
      end
    end
  end

  // Result side: random stall per transaction, plus one-off long hold-offs
  initial begin
    int n;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      n = no_idle ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Offers one transaction and returns at the edge where it is taken
  task automatic issue_op(kind_e k, logic [2:0] q, logic [31:0] v, bit use_typed,
                          result_t typed);
    int        gap;
    exp_hint_t hint;
    hint.use_typed = use_typed;
    hint.r         = typed;
    typed_hints.push_back(hint);
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    queue_index_i <= q;
    value_i       <= v;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_active_queues(logic [CfgW-1:0] n);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic add_row(row_e op, logic [2:0] q, logic [31:0] word, bit typed,
                         status_e st, logic [31:0] rv, logic ne);
    stim_row_t row;
    row.op          = op;
    row.q           = q;
    row.word        = word;
    row.typed       = typed;
    row.r.status    = st;
    row.r.value     = rv;
    row.r.now_empty = ne;
    plan.push_back(row);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus
  initial begin
    int          n_rand;
    int          phase;
    int          len;
    int          enq_pct;
    int          eff;
    logic [3:0]  cfg;
    logic [2:0]  q;
    kind_e       k;

    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, stored minus one, empty, bad index, register corners
    add_row(ROW_DEQ, 3'd0, 32'h0,         1, STAT_EMPTY,     32'h0,         1'b1);
    add_row(ROW_ENQ, 3'd7, 32'h7FFF_FFFF, 1, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_ENQ, 3'd7, 32'h8000_0000, 1, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_ENQ, 3'd7, 32'hFFFF_FFFF, 1, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_DEQ, 3'd7, 32'h0,         1, STAT_OK,        32'h7FFF_FFFF, 1'b0);
    add_row(ROW_DEQ, 3'd7, 32'h0,         1, STAT_OK,        32'h8000_0000, 1'b0);
    add_row(ROW_DEQ, 3'd7, 32'h0,         1, STAT_OK,        32'hFFFF_FFFF, 1'b1);
    add_row(ROW_DEQ, 3'd7, 32'h0,         1, STAT_EMPTY,     32'h0,         1'b1);
    add_row(ROW_ENQ, 3'd0, 32'h0,         1, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_ENQ, 3'd3, 32'hA5A5_A5A5, 0, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_CFG, 3'd0, 32'd1,         0, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_ENQ, 3'd1, 32'd5,         1, STAT_BAD_INDEX, 32'h0,         1'b1);
    add_row(ROW_DEQ, 3'd7, 32'h0,         1, STAT_BAD_INDEX, 32'h0,         1'b1);
    add_row(ROW_DEQ, 3'd0, 32'h0,         1, STAT_OK,        32'h0,         1'b1);
    add_row(ROW_DEQ, 3'd0, 32'h0,         1, STAT_EMPTY,     32'h0,         1'b1);
    add_row(ROW_CFG, 3'd0, 32'd0,         0, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_ENQ, 3'd0, 32'd1,         1, STAT_BAD_INDEX, 32'h0,         1'b1);
    add_row(ROW_DEQ, 3'd0, 32'h0,         1, STAT_BAD_INDEX, 32'h0,         1'b1);
    // above NUM_QUEUES acts as NUM_QUEUES
    add_row(ROW_CFG, 3'd0, 32'd15,        0, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_ENQ, 3'd7, 32'h1234_5678, 1, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_DEQ, 3'd3, 32'h0,         0, STAT_OK,        32'h0,         1'b0);
    // shrink: queue 7 keeps its entry while inactive
    add_row(ROW_CFG, 3'd0, 32'd7,         0, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_DEQ, 3'd7, 32'h0,         1, STAT_BAD_INDEX, 32'h0,         1'b1);
    add_row(ROW_ENQ, 3'd6, 32'h5A5A_5A5A, 0, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_CFG, 3'd0, 32'd8,         0, STAT_OK,        32'h0,         1'b0);
    add_row(ROW_DEQ, 3'd7, 32'h0,         1, STAT_OK,        32'h1234_5678, 1'b1);
    add_row(ROW_DEQ, 3'd6, 32'h0,         0, STAT_OK,        32'h0,         1'b0);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG)
        set_active_queues(plan[i].word[3:0]);
      else
        issue_op(plan[i].op == ROW_DEQ ? KIND_DEQ : KIND_ENQ, plan[i].q, plan[i].word,
                 plan[i].typed, plan[i].r);
    end

    // Random phases; phase 1 fills the pool past full, phase 2 drains it
    n_rand = 0;
    phase  = 0;
    while (n_rand < RandItems) begin
      case (phase)
        1: begin
          cfg     = 4'd8;
          len     = 400;
          enq_pct = 92;
        end
        2: begin
          cfg     = 4'd15;
          len     = 400;
          enq_pct = 8;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       cfg = 4'd0;
            1:       cfg = 4'd1;
            2:       cfg = 4'd15;
            3:       cfg = 4'd8;
            default: cfg = 4'($urandom_range(1, 15));
          endcase
          len     = (cfg == 0) ? 15 : $urandom_range(80, 200);
          enq_pct = $urandom_range(35, 65);
        end
      endcase
      set_active_queues(cfg);
      no_idle = (phase != 1) && ($urandom_range(0, 3) == 0);
      // long result hold-off while the sender keeps offering
      if (phase == 1 || phase == 4) hold_req = 1'b1;
      eff = (cfg > 8) ? 8 : cfg;
      repeat (len) begin
        if (eff > 0 && $urandom_range(0, 4) != 0) q = 3'($urandom_range(0, eff - 1));
        else q = 3'($urandom_range(0, 7));
        k = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        issue_op(k, q, rand_word(), 1'b0, '0);
        n_rand++;
      end
      phase++;
    end

    // Wind down and report
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("Checked %0d transactions over %0d register settings and %0d random phases.",
             n_checked, n_settings, phase);
    $display("Status mix: ok %0d, empty %0d, bad index %0d, pool full %0d; %0d mismatches.",
             stat_seen[STAT_OK], stat_seen[STAT_EMPTY], stat_seen[STAT_BAD_INDEX],
             stat_seen[STAT_POOL_FULL], err_cnt);
    if (err_cnt == 0) begin
      $display("[multi_queue_linked_buffer_top] OK");
    end else begin
      $display("[multi_queue_linked_buffer_top] ERROR");
    end
    $finish;
  end

endmodule
